// ===== hw/rtl/scca_pkg.sv =====
// Shared types and constants of the size-class chunk allocator.
`default_nettype none

package scca_pkg;

    // Chunk class is log2 of the chunk size.
    localparam int CLS_W = 4;

    // Chunk map words.
    localparam int MAP_W  = 32;
    localparam int MAP_IW = 5;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_TOO_BIG   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_OWNED = 3'd4,
        ST_DOUBLE    = 3'd5,
        ST_NO_MATCH  = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARD,
        S_ACHK,
        S_CLR,
        S_GEO,
        S_FIRST,
        S_MRD,
        S_MCHK,
        S_AADDR,
        S_FRD,
        S_FCHK,
        S_FIDX,
        S_FMRD,
        S_FMAP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             zero;
        logic             too_big;
        logic [CLS_W-1:0] cls;
    } size_info_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scca_size_class.sv =====
// Request size to chunk class decoder.
`default_nettype none

module scca_size_class #(
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic [31:0]         request_size,
    output scca_pkg::size_info_t     info
);
    import scca_pkg::*;

    localparam int PG_W = $clog2(PAGE_BYTES);

    logic [PG_W-1:0] span;
    logic [CLS_W-1:0] msb;

    // Raise to the minimum chunk, then find ceil(log2) from the top set bit of size-1
    always_comb begin
        if (request_size < 32'd8) begin
            span = PG_W'(7);
        end else begin
            span = PG_W'(request_size - 32'd1);
        end
        msb = '0;
        for (int i = 0; i < PG_W; i++) begin
            if (span[i]) begin
                msb = CLS_W'(i);
            end
        end
        info.zero    = (request_size == 32'd0);
        info.too_big = (request_size > 32'(PAGE_BYTES / 2));
        info.cls     = msb + CLS_W'(1);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/size_class_chunk_allocator.sv =====
// Top level of the power-of-two size-class chunk allocator.
//
//   channel | direction | handshake         | word
//   s_      | in        | s_valid/s_ready   | action, request_size, release_address
//   m_      | out       | m_valid/m_ready   | status, granted_address
//   cfg_    | in        | cfg_valid/cfg_ready | pool_base
//
// One request at a time. Allocate: accept, a read and a check per slot-table entry
// scanned (newest first, S_ARD/S_ACHK); if none fits, open a slot and clear its map
// word by word (S_CLR), then geometry (S_GEO, S_FIRST), a read and a check per
// chunk-map word (S_MRD/S_MCHK), the address (S_AADDR), the output load (S_DONE).
// Free: accept, a read and a check per slot (S_FRD/S_FCHK), then S_FIDX, S_FMRD and
// S_FMAP on a hit (S_FIDX alone off a chunk boundary), else straight to S_DONE, as for
// zero, oversize and null. Slot table and chunk map each have a single read port.
// Reset is synchronous; no clearing pass, a slot's map is swept when it opens.
// The result sits in an output register, so a new request is taken while it stalls.
`default_nettype none

module size_class_chunk_allocator #(
    parameter int PAGE_BYTES   = 4096,
    parameter int NUM_SLOTS    = 16,
    parameter int HEADER_BYTES = 28,
    parameter int MAX_CHUNKS   = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [31:0] s_request_size,
    input  wire logic [31:0] s_release_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_granted_address,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import scca_pkg::*;

    localparam int PG_W   = $clog2(PAGE_BYTES);
    localparam int SL_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OPN_W  = $clog2(NUM_SLOTS + 1);
    localparam int NC_W   = $clog2(MAX_CHUNKS + 1);
    localparam int J_W    = $clog2(MAX_CHUNKS);
    localparam int WPR    = (MAX_CHUNKS + MAP_W - 1) / MAP_W;
    localparam int WI_W   = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int MDEPTH = NUM_SLOTS * WPR;
    localparam int MA_W   = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int SE_W   = CLS_W + NC_W;
    localparam int NCLS   = 1 << CLS_W;

    // Chunks per slot for each class
    logic [NC_W-1:0] n_tab [NCLS];
    for (genvar g = 0; g < NCLS; g++) begin : g_ntab
        localparam int NV = (PAGE_BYTES - HEADER_BYTES) / (1 + (1 << g));
        assign n_tab[g] = NC_W'((NV > MAX_CHUNKS) ? MAX_CHUNKS : NV);
    end

    state_t state_reg, state_next;

    logic [31:0]       pool_base_reg;
    logic [OPN_W-1:0]  opened_reg;
    logic [OPN_W-1:0]  idx_reg;
    logic [SL_W-1:0]   slot_reg;
    logic [CLS_W-1:0]  k_reg;
    logic [NC_W-1:0]   cnt_reg;
    logic [WI_W-1:0]   w_reg;
    logic [J_W-1:0]    j_reg;
    logic [31:0]       base_reg;
    logic [32:0]       first_reg;
    logic [31:0]       rel_reg;
    status_t           res_status_reg;
    logic [31:0]       res_addr_reg;
    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [31:0]       m_addr_reg;

    size_info_t size_info;

    scca_size_class #(.PAGE_BYTES(PAGE_BYTES)) u_size (
        .request_size (s_request_size),
        .info         (size_info)
    );

    // Slot table: class and free count per slot
    logic [SE_W-1:0]  slot_mem [NUM_SLOTS];
    logic [SE_W-1:0]  slot_rdata_reg;
    logic             slot_we;
    logic [SL_W-1:0]  slot_addr;
    logic [SE_W-1:0]  slot_wdata;

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_addr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[slot_addr];
    end

    // Chunk used map, one row of words per slot
    logic [MAP_W-1:0] map_mem [MDEPTH];
    logic [MAP_W-1:0] map_rdata_reg;
    logic             map_we;
    logic [MA_W-1:0]  map_addr;
    logic [MAP_W-1:0] map_wdata;

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_addr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_addr];
    end

    logic [CLS_W-1:0] rd_cls;
    logic [NC_W-1:0]  rd_cnt;
    assign rd_cls = slot_rdata_reg[SE_W-1:NC_W];
    assign rd_cnt = slot_rdata_reg[NC_W-1:0];

    logic [SL_W-1:0] idx_slot;
    assign idx_slot = SL_W'(idx_reg - OPN_W'(1));

    // Slot geometry: first chunk address and slot end, no wrap
    logic [CLS_W-1:0] cls_sel;
    logic [32:0]      first_calc;
    logic [32:0]      end_calc;
    logic             free_hit;
    assign cls_sel    = (state_reg == S_FCHK) ? rd_cls : k_reg;
    assign first_calc = ({1'b0, base_reg} + 33'(HEADER_BYTES - 1) + 33'(n_tab[cls_sel]))
                        & ~33'd3;
    assign end_calc   = {1'b0, base_reg} + 33'(PAGE_BYTES);
    assign free_hit   = ({1'b0, rel_reg} >= first_calc) && ({1'b0, rel_reg} < end_calc);

    // Chunk index of a freed address
    logic [32:0]     diff;
    logic [PG_W-1:0] offs;
    logic [PG_W-1:0] jf;
    logic            free_bad;
    assign diff     = {1'b0, rel_reg} - first_reg;
    assign offs     = diff[PG_W-1:0];
    assign jf       = offs >> k_reg;
    assign free_bad = ((offs & ((PG_W'(1) << k_reg) - PG_W'(1))) != '0)
                      || (32'(jf) >= 32'(n_tab[k_reg]));

    // Lowest free chunk in a map word
    logic [MAP_IW-1:0] zero_pos;
    logic              word_full;
    always_comb begin
        zero_pos = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (!map_rdata_reg[i]) begin
                zero_pos = MAP_IW'(i);
            end
        end
    end
    assign word_full = (map_rdata_reg == '1);

    logic [MA_W-1:0] row_addr;
    assign row_addr = MA_W'(32'(slot_reg) * WPR);

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_action) begin
                        state_next = (s_release_address == 32'd0) ? S_DONE : S_FRD;
                    end else if (size_info.zero || size_info.too_big
                                 || n_tab[size_info.cls] == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_ARD;
                    end
                end
            end
            S_ARD: begin
                if (idx_reg != '0) begin
                    state_next = S_ACHK;
                end else if (opened_reg == OPN_W'(NUM_SLOTS)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_CLR;
                end
            end
            S_ACHK:  state_next = (rd_cls == k_reg && rd_cnt != '0) ? S_GEO : S_ARD;
            S_CLR:   state_next = (w_reg == WI_W'(WPR - 1)) ? S_GEO : S_CLR;
            S_GEO:   state_next = S_FIRST;
            S_FIRST: state_next = S_MRD;
            S_MRD:   state_next = S_MCHK;
            S_MCHK: begin
                if (!word_full) begin
                    state_next = S_AADDR;
                end else if (w_reg == WI_W'(WPR - 1)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_MRD;
                end
            end
            S_AADDR: state_next = S_DONE;
            S_FRD:   state_next = (idx_reg == '0) ? S_DONE : S_FCHK;
            S_FCHK:  state_next = free_hit ? S_FIDX : S_FRD;
            S_FIDX:  state_next = free_bad ? S_DONE : S_FMRD;
            S_FMRD:  state_next = S_FMAP;
            S_FMAP:  state_next = S_DONE;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Memory controls and handshake outputs
    always_comb begin
        s_ready    = (state_reg == S_IDLE);
        cfg_ready  = 1'b1;
        slot_we    = 1'b0;
        slot_addr  = idx_slot;
        slot_wdata = {k_reg, cnt_reg};
        map_we     = 1'b0;
        map_addr   = row_addr + MA_W'(w_reg);
        map_wdata  = '0;
        case (state_reg)
            S_ARD: begin
                if (idx_reg == '0 && opened_reg != OPN_W'(NUM_SLOTS)) begin
                    slot_we    = 1'b1;
                    slot_addr  = SL_W'(opened_reg);
                    slot_wdata = {k_reg, n_tab[k_reg]};
                end
            end
            S_CLR: begin
                map_we = 1'b1;
            end
            S_MCHK: begin
                if (!word_full) begin
                    map_we     = 1'b1;
                    map_wdata  = map_rdata_reg | (MAP_W'(1) << zero_pos);
                    slot_we    = 1'b1;
                    slot_addr  = slot_reg;
                    slot_wdata = {k_reg, cnt_reg - NC_W'(1)};
                end
            end
            S_FMRD: begin
                map_addr = row_addr + MA_W'(j_reg[J_W-1:MAP_IW]);
            end
            S_FMAP: begin
                map_addr = row_addr + MA_W'(j_reg[J_W-1:MAP_IW]);
                if (map_rdata_reg[j_reg[MAP_IW-1:0]]) begin
                    map_we     = 1'b1;
                    map_wdata  = map_rdata_reg & ~(MAP_W'(1) << j_reg[MAP_IW-1:0]);
                    slot_we    = 1'b1;
                    slot_addr  = slot_reg;
                    slot_wdata = {k_reg, cnt_reg + NC_W'(1)};
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pool_base_reg <= 32'h0010_0000;
            opened_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                pool_base_reg <= cfg_data;
            end
            if (state_reg == S_ARD && idx_reg == '0 && opened_reg != OPN_W'(NUM_SLOTS)) begin
                opened_reg <= opened_reg + OPN_W'(1);
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current request
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                idx_reg      <= opened_reg;
                k_reg        <= size_info.cls;
                rel_reg      <= s_release_address;
                res_addr_reg <= '0;
                if (s_action) begin
                    res_status_reg <= ST_NOT_OWNED;
                end else if (size_info.zero) begin
                    res_status_reg <= ST_ZERO;
                end else begin
                    res_status_reg <= ST_TOO_BIG;
                end
            end
            S_ARD: begin
                if (idx_reg == '0) begin
                    res_status_reg <= ST_FULL;
                    slot_reg       <= SL_W'(opened_reg);
                    cnt_reg        <= n_tab[k_reg];
                    w_reg          <= '0;
                end
            end
            S_ACHK: begin
                if (rd_cls == k_reg && rd_cnt != '0) begin
                    slot_reg <= idx_slot;
                    cnt_reg  <= rd_cnt;
                    w_reg    <= '0;
                end else begin
                    idx_reg <= idx_reg - OPN_W'(1);
                end
            end
            S_CLR: begin
                w_reg <= (w_reg == WI_W'(WPR - 1)) ? '0 : w_reg + WI_W'(1);
            end
            S_GEO: begin
                base_reg <= pool_base_reg + (32'(slot_reg) << PG_W);
            end
            S_FIRST: begin
                first_reg <= first_calc;
            end
            S_MCHK: begin
                if (!word_full) begin
                    j_reg <= J_W'({w_reg, zero_pos});
                end else begin
                    w_reg <= w_reg + WI_W'(1);
                end
            end
            S_AADDR: begin
                res_status_reg <= ST_OK;
                res_addr_reg   <= first_reg[31:0] + (32'(j_reg) << k_reg);
            end
            S_FRD: begin
                base_reg <= pool_base_reg + (32'(idx_slot) << PG_W);
            end
            S_FCHK: begin
                if (free_hit) begin
                    slot_reg  <= idx_slot;
                    k_reg     <= rd_cls;
                    cnt_reg   <= rd_cnt;
                    first_reg <= first_calc;
                end else begin
                    idx_reg <= idx_reg - OPN_W'(1);
                end
            end
            S_FIDX: begin
                res_status_reg <= ST_NO_MATCH;
                j_reg          <= J_W'(32'(jf));
            end
            S_FMAP: begin
                res_status_reg <= map_rdata_reg[j_reg[MAP_IW-1:0]] ? ST_OK : ST_DOUBLE;
            end
            default: begin
            end
        endcase
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= res_addr_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_address = m_addr_reg;

    a_opened_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        opened_reg <= OPN_W'(NUM_SLOTS))
        else $error("more slots opened than the pool holds");

    a_addr_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_granted_address == 32'd0))
        else $error("address granted with an error status");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request not processed");

    a_slot_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_we |-> (state_reg == S_ARD || state_reg == S_MCHK || state_reg == S_FMAP))
        else $error("slot table written outside a commit state");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == S_DONE))
        else $error("result word raised outside completion");

endmodule

`default_nettype wire
